// ===== rtl/sis_pkg.sv =====
package sis_pkg;

  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_CONTAINS = 2'd1,
    OP_GET      = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_CHK,
    S_ADD_CMP,
    S_CON_CHK,
    S_CON_CMP,
    S_GET_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_RANK
  } rd_sel_t;

  typedef struct packed {
    op_t                req_type;
    logic signed [31:0] key_value;
    logic [5:0]         rank_index;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
    status_t            status;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    idx_set_count;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_key;
    logic    cnt_inc;
    logic    cnt_clr;
    logic    finish;
    logic    found_flag;
    logic    take_value;
    status_t stat;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic idx_zero;
    logic idx_end;
    logic greater;
    logic equal;
    logic rank_ok;
  } sts_t;

endpackage

// ===== rtl/sis_ram.sv =====
module sis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sis_ctrl.sv =====
module sis_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sis_pkg::sts_t sts,
  output sis_pkg::cmd_t cmd,
  output logic          busy
);
  import sis_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.op)
          OP_ADD:      state_next = sts.full ? S_IDLE : S_ADD_CHK;
          OP_CONTAINS: state_next = S_CON_CHK;
          OP_GET:      state_next = sts.rank_ok ? S_GET_WAIT : S_IDLE;
          default:     state_next = S_IDLE;
        endcase
      end
      S_ADD_CHK: begin
        state_next = sts.idx_zero ? S_IDLE : S_ADD_CMP;
      end
      S_ADD_CMP: begin
        state_next = sts.greater ? S_ADD_CHK : S_IDLE;
      end
      S_CON_CHK: begin
        state_next = sts.idx_end ? S_IDLE : S_CON_CMP;
      end
      S_CON_CMP: begin
        state_next = sts.equal ? S_IDLE : S_CON_CHK;
      end
      S_GET_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    cmd.stat   = ST_OK;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        case (sts.op)
          OP_ADD: begin
            if (sts.full) begin
              cmd.finish = 1'b1;
              cmd.stat   = ST_FULL;
            end else begin
              cmd.idx_set_count = 1'b1;
            end
          end
          OP_CONTAINS: begin
            cmd.idx_clr = 1'b1;
          end
          OP_GET: begin
            if (sts.rank_ok) begin
              cmd.rd_sel = RD_RANK;
            end else begin
              cmd.finish = 1'b1;
              cmd.stat   = ST_RANGE;
            end
          end
          default: begin
            cmd.cnt_clr = 1'b1;
            cmd.finish  = 1'b1;
          end
        endcase
      end
      S_ADD_CHK: begin
        if (sts.idx_zero) begin
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.finish  = 1'b1;
        end else begin
          cmd.rd_sel = RD_PREV;
        end
      end
      S_ADD_CMP: begin
        if (sts.greater) begin
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
        end else begin
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.finish  = 1'b1;
        end
      end
      S_CON_CHK: begin
        if (sts.idx_end) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.rd_sel = RD_IDX;
        end
      end
      S_CON_CMP: begin
        if (sts.equal) begin
          cmd.finish     = 1'b1;
          cmd.found_flag = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_GET_WAIT: begin
        cmd.finish     = 1'b1;
        cmd.take_value = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/sis_dp.sv =====
module sis_dp #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  sis_pkg::req_t request,
  input  sis_pkg::cmd_t cmd,
  output sis_pkg::sts_t sts,
  output logic          done,
  output sis_pkg::rsp_t result
);
  import sis_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  req_t          req_q;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] idx_m1;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata, rdata;
  logic          we;
  rsp_t          rsp_next;

  assign idx_m1 = idx - CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: raddr = idx_m1[AW-1:0];
      RD_RANK: raddr = AW'(req_q.rank_index);
      default: raddr = idx[AW-1:0];
    endcase
  end

  assign we    = cmd.wr_shift | cmd.wr_key;
  assign waddr = idx[AW-1:0];
  assign wdata = cmd.wr_key ? req_q.key_value : rdata;

  sis_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    count_next = count;
    if (cmd.cnt_clr) begin
      count_next = '0;
    end else if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end
  end

  always_comb begin
    idx_next = idx;
    if (cmd.idx_set_count) begin
      idx_next = count;
    end else if (cmd.idx_clr) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + CW'(1);
    end else if (cmd.idx_dec) begin
      idx_next = idx_m1;
    end
  end

  always_comb begin
    sts.op       = req_q.req_type;
    sts.full     = (count == CW'(CAPACITY));
    sts.idx_zero = (idx == '0);
    sts.idx_end  = (idx == count);
    sts.greater  = ($signed(rdata) > req_q.key_value);
    sts.equal    = (rdata == req_q.key_value);
    sts.rank_ok  = (CMPW'(req_q.rank_index) < CMPW'(count));
  end

  always_comb begin
    rsp_next.found       = cmd.found_flag;
    rsp_next.read_value  = cmd.take_value ? $signed(rdata) : '0;
    rsp_next.entry_count = 7'(count_next);
    rsp_next.status      = cmd.stat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= request;
    end
    idx <= idx_next;
    if (cmd.finish) begin
      result <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> count == CW'(CAPACITY))
    else $error("full status while store has room");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.found |-> result.status == ST_OK && req_q.req_type == OP_CONTAINS)
    else $error("found set outside a contains request");

endmodule

// ===== rtl/sorted_integer_set_unit.sv =====
// Sorted integer set: signed 32-bit keys kept in ascending order, duplicates kept.
// Request channel: drive request and raise start; the request is taken on a clock
// edge where start is high and busy is low. Requests: add, contains, get by rank,
// clear. One request is worked on at a time; busy stays high until it is done.
// Result channel: done pulses for one cycle with result valid in that cycle.
// The receiver cannot stall; each result must be taken when done is high.
// Steps from the accepting edge to done:
//   clear, add when full, get out of range: finished in the decode state
//   get: the RAM is read at the requested rank, then the value is taken
//   add: every entry greater than the key is shifted up by one, from the top
//        down, then the key is written into the freed slot
//   contains: ranks are compared from 0 upward, stopping on a hit or at the count
// The entries sit in one RAM with a registered read port; each shift or compare
// step takes a read state and a compare state.
// Reset (rst, synchronous) empties the store; RAM contents are not cleared and
// need no clearing pass, since only ranks below the count are ever read.
// entry_count reports the count after the request, masked to 7 bits.
module sorted_integer_set_unit #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sis_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output sis_pkg::rsp_t result
);
  import sis_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sis_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  sis_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .request(request),
    .cmd    (cmd),
    .sts    (sts),
    .done   (done),
    .result (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

endmodule
